// ===== rtl/core/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, constants and the control store of the strided prime counter.
// ----------------------------------------------------------------------------
package spc_pkg;

  // configuration register layout
  localparam int OFFSET_W   = 8;
  localparam int STRIDE_W   = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_STRIDE = 8'd1;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd1;

  // arithmetic constants
  localparam int FIRST_CANDIDATE = 2;
  localparam int SMALL_PRIME_END = 4;
  localparam int FIRST_DIVISOR   = 3;
  localparam int FIRST_DIV_SQ    = 9;
  localparam int DIVISOR_STEP    = 2;
  localparam int SQ_STEP_BIAS    = 4;

  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_D,
    OP_DIV_GO,
    OP_STEP_D,
    OP_INC_COUNT,
    OP_NEXT_CAND,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_GT_LIMIT,
    C_LT4,
    C_EVEN,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic gt_limit;
    logic lt4;
    logic even;
    logic sq_gt;
    logic div_busy;
    logic rem_zero;
  } stat_t;

  // program steps
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_CHK_END   = 4'd1;
  localparam step_t S_CHK_SMALL = 4'd2;
  localparam step_t S_CHK_EVEN  = 4'd3;
  localparam step_t S_SET_D     = 4'd4;
  localparam step_t S_CHK_SQ    = 4'd5;
  localparam step_t S_DIV_GO    = 4'd6;
  localparam step_t S_DIV_WAIT  = 4'd7;
  localparam step_t S_CHK_REM   = 4'd8;
  localparam step_t S_STEP_D    = 4'd9;
  localparam step_t S_PRIME     = 4'd10;
  localparam step_t S_NEXT      = 4'd11;
  localparam step_t S_EMIT      = 4'd12;
  localparam step_t S_DONE      = 4'd13;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (s)
      S_IDLE:      w = '{op: OP_LOAD,      cond: C_NO_IN,    target: S_IDLE};
      S_CHK_END:   w = '{op: OP_NONE,      cond: C_GT_LIMIT, target: S_EMIT};
      S_CHK_SMALL: w = '{op: OP_NONE,      cond: C_LT4,      target: S_PRIME};
      S_CHK_EVEN:  w = '{op: OP_NONE,      cond: C_EVEN,     target: S_NEXT};
      S_SET_D:     w = '{op: OP_SET_D,     cond: C_NEVER,    target: S_IDLE};
      S_CHK_SQ:    w = '{op: OP_NONE,      cond: C_SQ_GT,    target: S_PRIME};
      S_DIV_GO:    w = '{op: OP_DIV_GO,    cond: C_NEVER,    target: S_IDLE};
      S_DIV_WAIT:  w = '{op: OP_NONE,      cond: C_DIV_BUSY, target: S_DIV_WAIT};
      S_CHK_REM:   w = '{op: OP_NONE,      cond: C_REM_ZERO, target: S_NEXT};
      S_STEP_D:    w = '{op: OP_STEP_D,    cond: C_ALWAYS,   target: S_CHK_SQ};
      S_PRIME:     w = '{op: OP_INC_COUNT, cond: C_NEVER,    target: S_IDLE};
      S_NEXT:      w = '{op: OP_NEXT_CAND, cond: C_ALWAYS,   target: S_CHK_END};
      S_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_FULL, target: S_EMIT};
      S_DONE:      w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE};
      default:     w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/spc_if.sv =====
// ----------------------------------------------------------------------------
// spc_if
// Valid/ready channels of the strided prime counter: request, result, config.
// ----------------------------------------------------------------------------
interface spc_in_if #(parameter int LIMIT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] upper_limit;

  modport source (output valid, output upper_limit, input ready);
  modport sink   (input valid, input upper_limit, output ready);
endinterface

interface spc_out_if #(parameter int LIMIT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

interface spc_cfg_if;
  import spc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/spc_rem.sv =====
// ----------------------------------------------------------------------------
// spc_rem
// Serial restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spc_rem #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] rem
);
  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     num_r, num_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W:0]       trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // partial remainder stays below den, so it fits W bits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[W-1:0];
      end
      num_nxt = {num_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/spc_dp.sv =====
// ----------------------------------------------------------------------------
// spc_dp
// Datapath: candidate, divisor and count registers, result register and the
// remainder unit, all driven by the current control word.
// ----------------------------------------------------------------------------
module spc_dp #(
  parameter int LIMIT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spc_pkg::ctrl_t                ctrl,
  input  logic [spc_pkg::OFFSET_W-1:0]  start_offset,
  input  logic [spc_pkg::STRIDE_W-1:0]  candidate_stride,
  output spc_pkg::stat_t                stat,
  spc_in_if.sink                        in_ch,
  spc_out_if.source                     out_ch
);
  import spc_pkg::*;

  // candidate may run one stride past the limit
  localparam int CW = ((LIMIT_BITS > STRIDE_W) ? LIMIT_BITS : STRIDE_W) + 1;
  localparam int DW = CW + 2;

  logic [LIMIT_BITS-1:0] limit_r, limit_nxt;
  logic [CW-1:0]         cand_r, cand_nxt;
  logic [LIMIT_BITS-1:0] count_r, count_nxt;
  logic [CW-1:0]         d_r, d_nxt;
  logic [DW-1:0]         dsq_r, dsq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LIMIT_BITS-1:0] out_count_r, out_count_nxt;
  logic [STRIDE_W-1:0]   step_val;
  logic                  out_full;
  logic                  div_busy;
  logic [CW-1:0]         rem;

  assign step_val = (candidate_stride == '0) ? STRIDE_W'(1) : candidate_stride;
  assign out_full = out_valid_r && !out_ch.ready;

  spc_rem #(.W(CW)) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.op == OP_DIV_GO),
    .num   (cand_r),
    .den   (d_r),
    .busy  (div_busy),
    .rem   (rem)
  );

  always_comb begin
    limit_nxt     = limit_r;
    cand_nxt      = cand_r;
    count_nxt     = count_r;
    d_nxt         = d_r;
    dsq_nxt       = dsq_r;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_full;
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_ch.valid) begin
          limit_nxt = in_ch.upper_limit;
          cand_nxt  = CW'(FIRST_CANDIDATE) + CW'(start_offset);
          count_nxt = '0;
        end
      end
      OP_SET_D: begin
        d_nxt   = CW'(FIRST_DIVISOR);
        dsq_nxt = DW'(FIRST_DIV_SQ);
      end
      OP_STEP_D: begin
        // (d+2)^2 = d^2 + 4d + 4
        d_nxt   = d_r + CW'(DIVISOR_STEP);
        dsq_nxt = dsq_r + {d_r, 2'b00} + DW'(SQ_STEP_BIAS);
      end
      OP_INC_COUNT: count_nxt = count_r + LIMIT_BITS'(1);
      OP_NEXT_CAND: cand_nxt  = cand_r + CW'(step_val);
      OP_EMIT: begin
        if (!out_full) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
        end
      end
      OP_NONE, OP_DIV_GO: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    limit_r     <= limit_nxt;
    cand_r      <= cand_nxt;
    count_r     <= count_nxt;
    d_r         <= d_nxt;
    dsq_r       <= dsq_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_ch.ready        = (ctrl.op == OP_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime_count = out_count_r;

  always_comb begin
    stat.in_valid = in_ch.valid;
    stat.out_full = out_full;
    stat.gt_limit = cand_r > CW'(limit_r);
    stat.lt4      = cand_r < CW'(SMALL_PRIME_END);
    stat.even     = !cand_r[0];
    stat.sq_gt    = dsq_r > DW'(cand_r);
    stat.div_busy = div_busy;
    stat.rem_zero = (rem == '0);
  end

endmodule

// ===== rtl/core/spc_seq.sv =====
// ----------------------------------------------------------------------------
// spc_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module spc_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  spc_pkg::stat_t stat,
  output spc_pkg::ctrl_t ctrl
);
  import spc_pkg::*;

  step_t pc_r, pc_nxt;
  logic  take;

  assign ctrl = ucode(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !stat.in_valid;
      C_GT_LIMIT: take = stat.gt_limit;
      C_LT4:      take = stat.lt4;
      C_EVEN:     take = stat.even;
      C_SQ_GT:    take = stat.sq_gt;
      C_DIV_BUSY: take = stat.div_busy;
      C_REM_ZERO: take = stat.rem_zero;
      C_OUT_FULL: take = stat.out_full;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/strided_prime_counter_top.sv =====
// ----------------------------------------------------------------------------
// strided_prime_counter_top
// Each request carries an upper limit; the block answers with the number of
// primes among 2+offset, 2+offset+stride, ... up to and including that limit.
// Offset and stride are to be set through the configuration channel while
// idle; the block itself does not enforce this. One request is worked at a
// time by a microcoded sequencer. An even candidate leaves after the end,
// small-prime and parity checks; an odd one also passes divisor set-up and,
// per trial divisor (odd, up to the square root of the candidate), a division
// in the serial remainder unit, where W = max(LIMIT_BITS, 9) + 1 is its width,
// that retires one quotient bit per cycle. A request is therefore bound by
// that remainder unit. The finished count sits in an output register, so the
// next request is taken while it waits to be read.
// ----------------------------------------------------------------------------
module strided_prime_counter_top #(
  parameter int LIMIT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  spc_in_if.sink   in_ch,
  spc_out_if.source out_ch,
  spc_cfg_if.sink  cfg_ch
);
  import spc_pkg::*;

  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  ctrl_t               ctrl;
  stat_t               stat;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    offset_nxt = offset_r;
    stride_nxt = stride_r;
    if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_START_OFFSET) begin
        offset_nxt = cfg_ch.data[OFFSET_W-1:0];
      end else if (cfg_ch.index == REG_CANDIDATE_STRIDE) begin
        stride_nxt = cfg_ch.data[STRIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      stride_r <= STRIDE_RESET;
    end else begin
      offset_r <= offset_nxt;
      stride_r <= stride_nxt;
    end
  end

  spc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  spc_dp #(.LIMIT_BITS(LIMIT_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .start_offset     (offset_r),
    .candidate_stride (stride_r),
    .stat             (stat),
    .in_ch            (in_ch),
    .out_ch           (out_ch)
  );

`ifndef ASSERT_OFF
  a_div_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV_GO) |-> !stat.div_busy)
    else $error("remainder unit started while busy");

  a_div_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV_GO) |=> stat.div_busy)
    else $error("remainder unit did not start");

  a_load_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.div_busy)
    else $error("item taken while a division runs");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

// ===== test/tb_strided_prime_counter_top.sv =====
// ----------------------------------------------------------------------------
// tb_strided_prime_counter_top
// Sends upper limits to the strided prime counter under several offset and
// stride settings, predicts each count by trial division and compares every
// result in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_strided_prime_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  localparam int LIMIT_BITS = 16;
  // rough cycles per trial divisor: serial remainder width plus overhead
  localparam int DIV_COST = ((LIMIT_BITS > 9) ? LIMIT_BITS + 1 : 10) + 5;
  localparam int CAND_COST = 8;
  localparam int WORK_BUDGET = 6000;
  localparam int IDLE_PCT = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = 8'hFF;

  logic clk;
  logic rst_n;

  spc_in_if #(.LIMIT_BITS(LIMIT_BITS)) in_ch();
  spc_out_if #(.LIMIT_BITS(LIMIT_BITS)) out_ch();
  spc_cfg_if cfg_ch();

  strided_prime_counter_top #(.LIMIT_BITS(LIMIT_BITS)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [LIMIT_BITS-1:0] limit_q[$];
  logic [LIMIT_BITS-1:0] count_q[$];
  logic [OFFSET_W-1:0] offset_cfg;
  logic [STRIDE_W-1:0] stride_cfg;
  logic in_taken;
  logic no_stall;
  int mismatches;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // primes among 2+offset, 2+offset+stride, ... up to limit; work is a cycle estimate
  function automatic logic [LIMIT_BITS-1:0] count_primes(
    input logic [LIMIT_BITS-1:0] limit,
    input logic [OFFSET_W-1:0] offset,
    input logic [STRIDE_W-1:0] stride,
    output int unsigned work
  );
    longint unsigned cand;
    longint unsigned d;
    longint unsigned step;
    longint unsigned lim;
    longint unsigned n;
    bit is_p;
    step = (stride == '0) ? 64'd1 : 64'(stride);
    lim = 64'(limit);
    n = 64'd0;
    work = 0;
    for (cand = 64'(FIRST_CANDIDATE) + 64'(offset); cand <= lim; cand += step) begin
      work += CAND_COST;
      if (cand < 64'(SMALL_PRIME_END)) begin
        is_p = 1'b1;
      end else if (cand[0] == 1'b0) begin
        is_p = 1'b0;
      end else begin
        is_p = 1'b1;
        for (d = 64'(FIRST_DIVISOR); is_p && d * d <= cand; d += 64'(DIVISOR_STEP)) begin
          work += DIV_COST;
          if (cand % d == 64'd0) is_p = 1'b0;
        end
      end
      if (is_p) n++;
    end
    return n[LIMIT_BITS-1:0];
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (limit_q.size() != 0 && (no_stall || $urandom_range(99) >= IDLE_PCT)) begin
        in_ch.valid <= 1'b1;
        in_ch.upper_limit <= limit_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: config shadow, expected counts, result check
  always @(posedge clk) begin : monitor
    logic [LIMIT_BITS-1:0] want;
    int unsigned work;
    if (!rst_n) begin
      offset_cfg <= '0;
      stride_cfg <= STRIDE_RESET;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_START_OFFSET:     offset_cfg <= cfg_ch.data[OFFSET_W-1:0];
          REG_CANDIDATE_STRIDE: stride_cfg <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (count_q.size() == 0) begin
          $error("prime_count: unexpected item, expected none, actual %0d",
                 out_ch.prime_count);
          mismatches++;
        end else begin
          want = count_q.pop_front();
          if (out_ch.prime_count !== want) begin
            $error("prime_count: expected %0d, actual %0d", want, out_ch.prime_count);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        count_q.push_back(count_primes(in_ch.upper_limit, offset_cfg, stride_cfg, work));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (limit_q.size() != 0 || in_ch.valid || count_q.size() != 0);
  endtask

  // random limits, shrunk until the request fits the work budget
  task automatic add_random(input int n);
    logic [LIMIT_BITS-1:0] limit;
    int unsigned work;
    repeat (n) begin
      case ($urandom_range(2))
        0:       limit = LIMIT_BITS'($urandom_range(64));
        1:       limit = LIMIT_BITS'($urandom_range(4095));
        default: limit = LIMIT_BITS'($urandom);
      endcase
      void'(count_primes(limit, offset_cfg, stride_cfg, work));
      while (work > WORK_BUDGET) begin
        limit = limit >> 1;
        void'(count_primes(limit, offset_cfg, stride_cfg, work));
      end
      limit_q.push_back(limit);
    end
  endtask

  task automatic random_config();
    logic [STRIDE_W-1:0] stride;
    case ($urandom_range(5))
      0:       stride = '0;
      1:       stride = 9'd1;
      2:       stride = STRIDE_W'($urandom_range(16, 2));
      3:       stride = 9'd256;
      4:       stride = STRIDE_W'($urandom_range(511, 257));
      default: stride = STRIDE_W'($urandom_range(255, 17));
    endcase
    case ($urandom_range(2))
      0:       write_reg(REG_START_OFFSET, {1'($urandom_range(1)), 8'h00});
      1:       write_reg(REG_START_OFFSET, {1'($urandom_range(1)), 8'hFF});
      default: write_reg(REG_START_OFFSET, CFG_DATA_W'($urandom));
    endcase
    write_reg(REG_CANDIDATE_STRIDE, stride);
    if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    no_stall = 1'b0;
    mismatches = 0;
    in_ch.valid = 1'b0;
    in_ch.upper_limit = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: limits below two, the small primes, squares
    limit_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49,
                16'd100, 16'd1000};
    wait_drained();

    // top bit of the offset data is dropped; even stride keeps full limits cheap
    write_reg(REG_START_OFFSET, 9'h100);
    write_reg(REG_CANDIDATE_STRIDE, 9'd256);
    limit_q = '{16'hFFFF, 16'h8000, 16'd258, 16'd257};
    wait_drained();

    // largest offset, stride above its nominal range; first candidate past limit
    write_reg(REG_START_OFFSET, 9'h1FF);
    write_reg(REG_CANDIDATE_STRIDE, 9'h1FF);
    limit_q = '{16'd256, 16'd257, 16'hFFFF};
    wait_drained();

    // unmapped indexes are ignored; zero stride steps by one
    write_reg(REG_UNMAPPED, 9'h1AA);
    write_reg(REG_IDX_TOP, 9'h000);
    write_reg(REG_CANDIDATE_STRIDE, 9'd0);
    limit_q = '{16'd300, 16'd258};
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      random_config();
      no_stall = (ph == 2);
      add_random(20);
      wait_drained();
    end
    no_stall = 1'b0;

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spc_pkg.sv
rtl/core/spc_if.sv
rtl/core/spc_rem.sv
rtl/core/spc_dp.sv
rtl/core/spc_seq.sv
rtl/core/strided_prime_counter_top.sv
test/tb_strided_prime_counter_top.sv
